### rtl/ffha_pkg.sv
package ffha_pkg;

  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ZERO     = 3'd1;
  localparam logic [2:0] ST_OOM      = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  localparam logic CFG_HEAP_START = 1'b0;
  localparam logic CFG_HEAP_BYTES = 1'b1;

  localparam logic [12:0] ALIGN_FLOOR = 13'd16;

  typedef struct packed {
    logic        free;
    logic [31:0] size;
    logic [31:0] start;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_SCAN, S_GROW_CALC, S_GROW, S_SPLIT_CALC, S_SPLIT,
    S_SHUP, S_SHUP_WR, S_ALLOC_WR, S_DIV, S_FNX, S_FNX_CK, S_SHDN, S_SHDN_WR,
    S_FPV, S_FPV_CK, S_DONE
  } ctl_state_t;

  typedef enum logic [4:0] {
    C_NOP, C_LOAD, C_INIT, C_SET_OOM, C_SET_ZERO, C_SET_FULL, C_SET_NF, C_RD,
    C_NEXT, C_CAPTURE, C_GROW_CALC, C_EXTEND, C_APPEND, C_SPLIT_CALC,
    C_SHUP_RD, C_SHUP_WR, C_INSERT, C_ALLOC_WR, C_SET_ADDR, C_RD_NEXT_BLK,
    C_MERGE_NEXT, C_SHDN_RD, C_SHDN_WR, C_CNT_DEC, C_RD_PREV_BLK,
    C_MERGE_PREV, C_WR_FREE
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       cnt_zero;
    logic       req_zero;
    logic       faddr_zero;
    logic       match;
    logic       idx_last;
    logic       grow_oom;
    logic       grow_ext;
    logic       tbl_full;
    logic       split_ok;
    logic       shup_done;
    logic       shdn_done;
    logic       next_exists;
    logic       prev_exists;
    logic       rd_free;
    logic       div_done;
  } dp_stat_t;

endpackage

### rtl/ffha_if.sv
interface ffha_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [24:0] request_bytes;
  logic [12:0] alignment;
  logic [31:0] free_address;

  modport source (output valid, output opcode, output request_bytes, output alignment,
                  output free_address, input ready);
  modport sink (input valid, input opcode, input request_bytes, input alignment,
                input free_address, output ready);
endinterface

interface ffha_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] address;
  logic [2:0]  status;

  modport source (output valid, output address, output status, input ready);
  modport sink (input valid, input address, input status, output ready);
endinterface

### rtl/ffha_ram.sv
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/ffha_rem_unit.sv
module ffha_rem_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [32:0] x,
  input  logic [12:0] d,
  output logic        done,
  output logic [31:0] result
);

  logic        busy;
  logic [5:0]  cnt;
  logic [32:0] sh;
  logic [32:0] xr;
  logic [12:0] dr;
  logic [12:0] rem;
  logic [13:0] rem2;

  assign rem2 = {rem, sh[32]};
  assign result = (rem == 13'd0) ? xr[31:0] : 32'(xr + 33'(dr) - 33'(rem));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= x;
      xr  <= x;
      dr  <= d;
      rem <= 13'd0;
      cnt <= 6'd33;
    end else if (busy) begin
      if (rem2 >= {1'b0, dr}) begin
        rem <= 13'(rem2 - {1'b0, dr});
      end else begin
        rem <= rem2[12:0];
      end
      sh  <= sh << 1;
      cnt <= cnt - 6'd1;
    end
  end

endmodule

### rtl/ffha_dp.sv
module ffha_dp
  import ffha_pkg::*;
#(
  parameter int MAX_BLOCKS      = 64,
  parameter int PAGE_BYTES      = 4096,
  parameter int MIN_SPLIT_BYTES = 32,
  parameter int HEADER_BYTES    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [1:0]  opcode,
  input  logic [24:0] request_bytes,
  input  logic [12:0] alignment,
  input  logic [31:0] free_address,
  output logic [31:0] address,
  output logic [2:0]  status
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [33:0] HDR = 34'(HEADER_BYTES);
  localparam logic [33:0] PAGE34 = 34'(PAGE_BYTES);
  localparam logic [33:0] PMASK = ~(PAGE34 - 34'd1);
  localparam logic [31:0] SPLIT_MIN = 32'(HEADER_BYTES + MIN_SPLIT_BYTES);
  localparam logic [31:0] HDR32 = 32'(HEADER_BYTES);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);

  logic [31:0]   heap_start;
  logic [24:0]   heap_bytes;
  logic [CW-1:0] count;
  logic [31:0]   reserved;
  logic [1:0]    op;
  logic          req_zero;
  logic [31:0]   faddr;
  logic [26:0]   req;
  logic [12:0]   align;
  logic [IW-1:0] idx;
  logic [IW-1:0] b;
  entry_t        cur;
  logic [33:0]   want;
  logic          grow_oom;
  logic          grow_ext;
  logic [31:0]   remain;
  logic [31:0]   addr_r;
  logic [2:0]    stat_r;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [IW-1:0] ram_raddr;
  entry_t        rd;

  logic [25:0]   size_r16;
  logic [12:0]   align_eff;
  logic [26:0]   req_in;
  logic [32:0]   origin;
  logic [33:0]   page_up;
  logic [33:0]   top;
  logic          init_oom;
  logic [33:0]   grow_amt;
  logic [33:0]   want_c;
  logic [32:0]   limit;
  logic [33:0]   tail_end;
  entry_t        ins;
  logic [31:0]   merged_next;
  logic [31:0]   merged_prev;
  logic          div_done;
  logic [31:0]   div_result;

  ffha_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_BLOCKS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  ffha_rem_unit u_rem (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd == C_ALLOC_WR),
    .x      ({1'b0, cur.start} + 33'(HEADER_BYTES)),
    .d      (align),
    .done   (div_done),
    .result (div_result)
  );

  always_comb begin
    size_r16  = ({1'b0, request_bytes} + 26'd15) & ~26'hF;
    align_eff = (alignment < ALIGN_FLOOR) ? ALIGN_FLOOR : alignment;
    req_in    = 27'(size_r16) + 27'(align_eff);

    origin   = ({1'b0, heap_start} + 33'd15) & ~33'hF;
    page_up  = ({1'b0, origin} + PAGE34 - 34'd1) & PMASK;
    top      = page_up + PAGE34;
    init_oom = (top[33:32] != 2'd0);

    grow_amt = ({7'd0, req} + HDR + PAGE34 - 34'd1) & PMASK;
    want_c   = {2'd0, reserved} + grow_amt;
    limit    = {1'b0, heap_start} + {8'd0, heap_bytes};
    tail_end = {2'd0, cur.start} + HDR + {2'd0, cur.size};

    ins.free  = 1'b1;
    ins.start = cur.start + HDR32 + 32'(req);
    ins.size  = remain - HDR32;

    merged_next = cur.size + HDR32 + rd.size;
    merged_prev = rd.size + HDR32 + cur.size;
  end

  always_comb begin
    stat.op          = op;
    stat.cnt_zero    = (count == '0);
    stat.req_zero    = req_zero;
    stat.faddr_zero  = (faddr == 32'd0);
    if (op == OP_FREE) begin
      stat.match = (({2'd0, rd.start} + HDR) == {2'd0, faddr});
    end else begin
      stat.match = rd.free && (rd.size >= 32'(req));
    end
    stat.idx_last    = (CW'(idx) + CW'(1)) == count;
    stat.grow_oom    = grow_oom;
    stat.grow_ext    = grow_ext;
    stat.tbl_full    = (count == CNT_MAX);
    stat.split_ok    = (remain >= SPLIT_MIN) && (count != CNT_MAX);
    stat.shup_done   = (idx == b);
    stat.shdn_done   = (CW'(idx) + CW'(1)) >= count;
    stat.next_exists = (CW'(b) + CW'(1)) < count;
    stat.prev_exists = (b != '0);
    stat.rd_free     = rd.free;
    stat.div_done    = div_done;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = rd;
    ram_raddr = idx;
    case (cmd)
      C_INIT: begin
        ram_we    = !init_oom;
        ram_waddr = '0;
        ram_wdata = {1'b1, 32'(top - {1'b0, origin} - HDR), origin[31:0]};
      end
      C_NEXT:        ram_raddr = idx + IW'(1);
      C_SHUP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx + IW'(1);
      end
      C_INSERT: begin
        ram_we    = 1'b1;
        ram_waddr = b + IW'(1);
        ram_wdata = ins;
      end
      C_ALLOC_WR: begin
        ram_we    = 1'b1;
        ram_waddr = b;
        ram_wdata = {1'b0, cur.size, cur.start};
      end
      C_RD_NEXT_BLK: ram_raddr = b + IW'(1);
      C_SHDN_RD:     ram_raddr = idx + IW'(1);
      C_SHDN_WR:     ram_we = 1'b1;
      C_RD_PREV_BLK: ram_raddr = b - IW'(1);
      C_MERGE_PREV: begin
        ram_we    = 1'b1;
        ram_waddr = b - IW'(1);
        ram_wdata = {1'b1, merged_prev, rd.start};
      end
      C_WR_FREE: begin
        ram_we    = 1'b1;
        ram_waddr = b;
        ram_wdata = {1'b1, cur.size, cur.start};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_start <= 32'd1048576;
      heap_bytes <= 25'd1048576;
      count      <= '0;
      reserved   <= 32'd0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_HEAP_START) begin
          heap_start <= cfg_data;
        end else begin
          heap_bytes <= cfg_data[24:0];
        end
      end
      case (cmd)
        C_INIT: begin
          if (init_oom) begin
            count    <= '0;
            reserved <= 32'd0;
          end else begin
            count    <= CW'(1);
            reserved <= top[31:0];
          end
        end
        C_EXTEND: reserved <= want[31:0];
        C_APPEND: begin
          reserved <= want[31:0];
          count    <= count + CW'(1);
        end
        C_INSERT:  count <= count + CW'(1);
        C_CNT_DEC: count <= count - CW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      C_LOAD: begin
        op       <= opcode;
        req      <= req_in;
        req_zero <= (request_bytes == 25'd0);
        align    <= align_eff;
        faddr    <= free_address;
        idx      <= '0;
        addr_r   <= 32'd0;
        stat_r   <= ST_OK;
      end
      C_INIT:      stat_r <= init_oom ? ST_OOM : ST_OK;
      C_SET_OOM:   stat_r <= ST_OOM;
      C_SET_ZERO:  stat_r <= ST_ZERO;
      C_SET_FULL:  stat_r <= ST_FULL;
      C_SET_NF:    stat_r <= ST_NOTFOUND;
      C_NEXT:      idx <= idx + IW'(1);
      C_CAPTURE: begin
        b   <= idx;
        cur <= rd;
      end
      C_GROW_CALC: begin
        want     <= want_c;
        grow_oom <= (want_c > {1'b0, limit}) || (want_c[33:32] != 2'd0);
        grow_ext <= cur.free && (tail_end == {2'd0, reserved});
      end
      C_EXTEND: cur.size <= cur.size + 32'(want - {2'd0, reserved});
      C_APPEND: begin
        b         <= IW'(count);
        cur.free  <= 1'b1;
        cur.size  <= 32'(want - {2'd0, reserved} - HDR);
        cur.start <= reserved;
      end
      C_SPLIT_CALC: begin
        remain <= cur.size - 32'(req);
        idx    <= IW'(count - CW'(1));
      end
      C_SHUP_WR:    idx <= idx - IW'(1);
      C_INSERT:     cur.size <= 32'(req);
      C_SET_ADDR:   addr_r <= div_result;
      C_MERGE_NEXT: begin
        cur.size <= merged_next;
        idx      <= b + IW'(1);
      end
      C_SHDN_WR:    idx <= idx + IW'(1);
      C_MERGE_PREV: idx <= b;
      default: ;
    endcase
  end

  assign address = addr_r;
  assign status  = stat_r;

endmodule

### rtl/ffha_ctl.sv
module ffha_ctl
  import ffha_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctl_state_t state, state_next;
  logic       out_vld, out_vld_next;
  logic       prev_phase, prev_phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_vld    <= 1'b0;
      prev_phase <= 1'b0;
    end else begin
      state      <= state_next;
      out_vld    <= out_vld_next;
      prev_phase <= prev_phase_next;
    end
  end

  always_comb begin
    state_next      = state;
    cmd             = C_NOP;
    prev_phase_next = prev_phase;
    req_ready       = (state == S_IDLE) && (!out_vld || rsp_ready);
    out_vld_next    = out_vld && !rsp_ready;
    case (state)
      S_IDLE: begin
        if (req_valid && req_ready) begin
          cmd        = C_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_DONE;
        case (stat.op)
          OP_INIT: cmd = C_INIT;
          OP_ALLOC: begin
            if (stat.cnt_zero) begin
              cmd = C_SET_OOM;
            end else if (stat.req_zero) begin
              cmd = C_SET_ZERO;
            end else begin
              cmd        = C_RD;
              state_next = S_SCAN;
            end
          end
          OP_FREE: begin
            if (stat.faddr_zero) begin
              cmd = C_NOP;
            end else if (stat.cnt_zero) begin
              cmd = C_SET_NF;
            end else begin
              cmd        = C_RD;
              state_next = S_SCAN;
            end
          end
          default: cmd = C_NOP;
        endcase
      end
      S_SCAN: begin
        if (stat.match) begin
          cmd        = C_CAPTURE;
          state_next = (stat.op == OP_ALLOC) ? S_SPLIT_CALC : S_FNX;
        end else if (stat.idx_last) begin
          if (stat.op == OP_ALLOC) begin
            cmd        = C_CAPTURE;
            state_next = S_GROW_CALC;
          end else begin
            cmd        = C_SET_NF;
            state_next = S_DONE;
          end
        end else begin
          cmd = C_NEXT;
        end
      end
      S_GROW_CALC: begin
        cmd        = C_GROW_CALC;
        state_next = S_GROW;
      end
      S_GROW: begin
        if (stat.grow_oom) begin
          cmd        = C_SET_OOM;
          state_next = S_DONE;
        end else if (stat.grow_ext) begin
          cmd        = C_EXTEND;
          state_next = S_SPLIT_CALC;
        end else if (stat.tbl_full) begin
          cmd        = C_SET_FULL;
          state_next = S_DONE;
        end else begin
          cmd        = C_APPEND;
          state_next = S_SPLIT_CALC;
        end
      end
      S_SPLIT_CALC: begin
        cmd        = C_SPLIT_CALC;
        state_next = S_SPLIT;
      end
      S_SPLIT: state_next = stat.split_ok ? S_SHUP : S_ALLOC_WR;
      S_SHUP: begin
        if (stat.shup_done) begin
          cmd        = C_INSERT;
          state_next = S_ALLOC_WR;
        end else begin
          cmd        = C_SHUP_RD;
          state_next = S_SHUP_WR;
        end
      end
      S_SHUP_WR: begin
        cmd        = C_SHUP_WR;
        state_next = S_SHUP;
      end
      S_ALLOC_WR: begin
        cmd        = C_ALLOC_WR;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd        = C_SET_ADDR;
          state_next = S_DONE;
        end
      end
      S_FNX: begin
        prev_phase_next = 1'b0;
        if (stat.next_exists) begin
          cmd        = C_RD_NEXT_BLK;
          state_next = S_FNX_CK;
        end else begin
          state_next = S_FPV;
        end
      end
      S_FNX_CK: begin
        if (stat.rd_free) begin
          cmd        = C_MERGE_NEXT;
          state_next = S_SHDN;
        end else begin
          state_next = S_FPV;
        end
      end
      S_SHDN: begin
        if (stat.shdn_done) begin
          cmd        = C_CNT_DEC;
          state_next = prev_phase ? S_DONE : S_FPV;
        end else begin
          cmd        = C_SHDN_RD;
          state_next = S_SHDN_WR;
        end
      end
      S_SHDN_WR: begin
        cmd        = C_SHDN_WR;
        state_next = S_SHDN;
      end
      S_FPV: begin
        if (stat.prev_exists) begin
          cmd        = C_RD_PREV_BLK;
          state_next = S_FPV_CK;
        end else begin
          cmd        = C_WR_FREE;
          state_next = S_DONE;
        end
      end
      S_FPV_CK: begin
        if (stat.rd_free) begin
          cmd             = C_MERGE_PREV;
          prev_phase_next = 1'b1;
          state_next      = S_SHDN;
        end else begin
          cmd        = C_WR_FREE;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        out_vld_next = 1'b1;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign rsp_valid = out_vld;

endmodule

### rtl/first_fit_heap_allocator.sv
// Channel   Direction  Carries
// req_ch    in         opcode, request_bytes, alignment, free_address
// rsp_ch    out        address, status
// cfg       in         cfg_write, cfg_index, cfg_data (no read-back)
//
// One transaction is worked on at a time. An allocate scans the block table one
// entry per cycle, then moves table entries up one by one when it splits a block
// and waits for the alignment remainder unit; a free scans, then moves entries down
// one by one for each merge. The table RAM, with one read and one write port, sets
// the pace of the scan and of these moves.
// Reset is synchronous and leaves an empty table; the response register holds until taken.
module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int MAX_BLOCKS      = 64,
  parameter int PAGE_BYTES      = 4096,
  parameter int MIN_SPLIT_BYTES = 32,
  parameter int HEADER_BYTES    = 16
) (
  input  logic        clk,
  input  logic        rst,
  ffha_req_if.sink    req_ch,
  ffha_rsp_if.source  rsp_ch,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ffha_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_ch.valid),
    .req_ready (req_ch.ready),
    .rsp_valid (rsp_ch.valid),
    .rsp_ready (rsp_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ffha_dp #(
    .MAX_BLOCKS      (MAX_BLOCKS),
    .PAGE_BYTES      (PAGE_BYTES),
    .MIN_SPLIT_BYTES (MIN_SPLIT_BYTES),
    .HEADER_BYTES    (HEADER_BYTES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .opcode        (req_ch.opcode),
    .request_bytes (req_ch.request_bytes),
    .alignment     (req_ch.alignment),
    .free_address  (req_ch.free_address),
    .address       (rsp_ch.address),
    .status        (rsp_ch.status)
  );

`ifndef SYNTHESIS
  a_ready_needs_room: assert property (@(posedge clk) disable iff (rst)
    req_ch.ready |-> (!rsp_ch.valid || rsp_ch.ready))
    else $error("input taken while the response register is occupied");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
    else $error("second transaction accepted while one is in progress");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_ch.valid |-> (rsp_ch.status <= ST_NOTFOUND))
    else $error("undefined status code");

  a_err_no_addr: assert property (@(posedge clk) disable iff (rst)
    (rsp_ch.valid && rsp_ch.status != ST_OK) |-> (rsp_ch.address == 32'd0))
    else $error("failed request returned an address");
`endif

endmodule

### verif/first_fit_heap_allocator_tb.sv
`timescale 1ns / 1ps

module first_fit_heap_allocator_tb
  import ffha_pkg::*;
();

  localparam int TBL_DEPTH  = 64;
  localparam int PAGE       = 4096;
  localparam int HDR        = 16;
  localparam int SPLIT_MIN  = 32;
  localparam longint unsigned ADDR_MAX = 64'hFFFF_FFFF;

  typedef struct {
    logic [31:0] address;
    logic [2:0]  status;
  } alloc_result_t;

  logic clk;
  logic rst;
  logic        cfg_write;
  logic        cfg_index;
  logic [31:0] cfg_data;

  ffha_req_if req ();
  ffha_rsp_if rsp ();

  first_fit_heap_allocator u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_ch    (req),
    .rsp_ch    (rsp),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the heap table and the configuration.
  logic [31:0] cfg_heap_start;
  logic [24:0] cfg_heap_bytes;
  logic [31:0] blk_base [TBL_DEPTH];
  logic [31:0] blk_len [TBL_DEPTH];
  bit          blk_avail [TBL_DEPTH];
  int          blk_n;
  logic [31:0] heap_top;

  alloc_result_t expected_q [$];
  int errors;
  int sent_count;
  int checked_count;
  int sender_idle_pct;
  int receiver_stall_pct;

  always #6 clk = ~clk;

  function automatic longint unsigned round_to(longint unsigned x, longint unsigned a);
    return ((x + a - 1) / a) * a;
  endfunction

  task automatic table_insert(int pos, longint unsigned base, longint unsigned len);
    for (int i = blk_n; i > pos; i--) begin
      blk_base[i]  = blk_base[i-1];
      blk_len[i]   = blk_len[i-1];
      blk_avail[i] = blk_avail[i-1];
    end
    blk_base[pos]  = base[31:0];
    blk_len[pos]   = len[31:0];
    blk_avail[pos] = 1'b1;
    blk_n++;
  endtask

  task automatic table_remove(int pos);
    for (int i = pos; i + 1 < blk_n; i++) begin
      blk_base[i]  = blk_base[i+1];
      blk_len[i]   = blk_len[i+1];
      blk_avail[i] = blk_avail[i+1];
    end
    blk_n--;
  endtask

  task automatic heap_setup(output logic [2:0] st);
    longint unsigned origin;
    longint unsigned top;
    origin = round_to(cfg_heap_start, 16);
    top = round_to(origin, PAGE) + PAGE;
    if (top > ADDR_MAX) begin
      blk_n = 0;
      heap_top = '0;
      st = ST_OOM;
    end else begin
      heap_top = top[31:0];
      blk_base[0] = origin[31:0];
      blk_len[0] = 32'(top - origin - HDR);
      blk_avail[0] = 1'b1;
      blk_n = 1;
      st = ST_OK;
    end
  endtask

  task automatic heap_alloc(input logic [24:0] sz, input logic [12:0] al,
                            output logic [31:0] addr, output logic [2:0] st);
    longint unsigned align;
    longint unsigned need;
    longint unsigned want;
    longint unsigned lend;
    longint unsigned remain;
    int b;
    int last;
    bit hit;
    addr = '0;
    st = ST_OK;
    b = 0;
    hit = 0;
    if (blk_n == 0) begin
      st = ST_OOM;
      return;
    end
    if (sz == 0) begin
      st = ST_ZERO;
      return;
    end
    align = (al < ALIGN_FLOOR) ? 16 : al;
    need = round_to(sz, 16) + align;
    for (int i = 0; i < blk_n; i++) begin
      if (!hit && blk_avail[i] && blk_len[i] >= need) begin
        b = i;
        hit = 1;
      end
    end
    if (!hit) begin
      want = heap_top + round_to(need + HDR, PAGE);
      if (want > longint'(cfg_heap_start) + longint'(cfg_heap_bytes) || want > ADDR_MAX) begin
        st = ST_OOM;
        return;
      end
      last = blk_n - 1;
      lend = longint'(blk_base[last]) + HDR + blk_len[last];
      if (blk_avail[last] && lend == heap_top) begin
        blk_len[last] = 32'(blk_len[last] + (want - heap_top));
        b = last;
      end else begin
        if (blk_n >= TBL_DEPTH) begin
          st = ST_FULL;
          return;
        end
        table_insert(blk_n, heap_top, want - heap_top - HDR);
        b = blk_n - 1;
      end
      heap_top = want[31:0];
    end
    remain = longint'(blk_len[b]) - need;
    if (remain >= HDR + SPLIT_MIN && blk_n < TBL_DEPTH) begin
      table_insert(b + 1, longint'(blk_base[b]) + HDR + need, remain - HDR);
      blk_len[b] = need[31:0];
    end
    blk_avail[b] = 1'b0;
    addr = 32'(round_to(longint'(blk_base[b]) + HDR, align));
  endtask

  task automatic heap_release(input logic [31:0] fa, output logic [2:0] st);
    int b;
    bit hit;
    b = 0;
    hit = 0;
    st = ST_OK;
    if (fa == 0) return;
    for (int i = 0; i < blk_n; i++) begin
      if (!hit && longint'(blk_base[i]) + HDR == longint'(fa)) begin
        b = i;
        hit = 1;
      end
    end
    if (!hit) begin
      st = ST_NOTFOUND;
      return;
    end
    blk_avail[b] = 1'b1;
    if (b + 1 < blk_n && blk_avail[b+1]) begin
      blk_len[b] = blk_len[b] + HDR + blk_len[b+1];
      table_remove(b + 1);
    end
    if (b > 0 && blk_avail[b-1]) begin
      blk_len[b-1] = blk_len[b-1] + HDR + blk_len[b];
      table_remove(b);
    end
  endtask

  task automatic predict_heap_op(logic [1:0] op, logic [24:0] sz, logic [12:0] al,
                                 logic [31:0] fa);
    alloc_result_t r;
    r.address = '0;
    r.status = ST_OK;
    if (op == OP_INIT) heap_setup(r.status);
    else if (op == OP_ALLOC) heap_alloc(sz, al, r.address, r.status);
    else if (op == OP_FREE) heap_release(fa, r.status);
    expected_q.push_back(r);
  endtask

  task automatic report_mismatch(string what);
    errors++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  task automatic send_item(logic [1:0] op, logic [24:0] sz, logic [12:0] al, logic [31:0] fa);
    if (sender_idle_pct > 0) begin
      while ($urandom_range(99) < sender_idle_pct) begin
        req.valid <= 1'b0;
        @(posedge clk);
      end
    end
    req.valid <= 1'b1;
    req.opcode <= op;
    req.request_bytes <= sz;
    req.alignment <= al;
    req.free_address <= fa;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predict_heap_op(op, sz, al, fa);
    sent_count++;
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_config(logic [31:0] hs, logic [24:0] hb);
    cfg_write <= 1'b1;
    cfg_index <= CFG_HEAP_START;
    cfg_data <= hs;
    @(posedge clk);
    cfg_index <= CFG_HEAP_BYTES;
    cfg_data <= {7'd0, hb};
    @(posedge clk);
    cfg_write <= 1'b0;
    cfg_heap_start = hs;
    cfg_heap_bytes = hb;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_free_address();
    int r;
    r = $urandom_range(99);
    if (r < 75 && blk_n > 0) return blk_base[$urandom_range(blk_n - 1)] + HDR;
    if (r < 85) return '0;
    if (r < 92 && blk_n > 0) return blk_base[$urandom_range(blk_n - 1)] + 8;
    return $urandom;
  endfunction

  task automatic send_random_item();
    int r;
    logic [24:0] sz;
    logic [12:0] al;
    r = $urandom_range(99);
    if ($urandom_range(99) < 80) al = 13'd1 << $urandom_range(12);
    else al = 13'($urandom);
    case ($urandom_range(99)) inside
      [0:79]:  sz = 25'($urandom_range(600, 1));
      [80:91]: sz = 25'($urandom_range(20000, 1));
      [92:96]: sz = 25'($urandom);
      default: sz = '0;
    endcase
    if (r < 4) send_item(OP_INIT, 25'($urandom), 13'($urandom), $urandom);
    else if (r < 7) send_item(2'd3, 25'($urandom), 13'($urandom), $urandom);
    else if (r < 55) send_item(OP_ALLOC, sz, al, $urandom);
    else send_item(OP_FREE, 25'($urandom), 13'($urandom), pick_free_address());
  endtask

  task automatic test_directed();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    send_item(OP_ALLOC, 25'd64, 13'd16, '0);
    send_item(OP_FREE, '0, '0, 32'h0010_0010);
    send_item(2'd3, 25'h1FF_FFFF, 13'h1FFF, 32'hFFFF_FFFF);
    send_item(OP_INIT, '0, '0, '0);
    send_item(OP_ALLOC, 25'd0, 13'd16, '0);
    send_item(OP_ALLOC, 25'd1, 13'd1, '0);
    send_item(OP_ALLOC, 25'd16, 13'd4096, '0);
    send_item(OP_ALLOC, 25'd2000, 13'd100, '0);
    send_item(OP_ALLOC, 25'd5000, 13'd0, '0);
    send_item(OP_ALLOC, 25'd9000, 13'h1FFF, '0);
    send_item(OP_FREE, '0, '0, '0);
    send_item(OP_FREE, '0, '0, 32'hFFFF_FFFF);
    send_item(OP_FREE, '0, '0, blk_base[1] + HDR);
    send_item(OP_FREE, '0, '0, blk_base[1] + HDR);
    send_item(OP_FREE, '0, '0, blk_base[0] + HDR);
    send_item(OP_ALLOC, 25'd16777216, 13'd16, '0);
    send_item(OP_ALLOC, 25'hFF_FFFF, 13'd2048, '0);
    send_item(OP_ALLOC, 25'd300, 13'd8, '0);
    send_item(OP_INIT, '0, '0, '0);
    wait_drained();
  endtask

  task automatic test_table_fill();
    sender_idle_pct = 30;
    receiver_stall_pct = 30;
    send_item(OP_INIT, '0, '0, '0);
    for (int i = 0; i < 90; i++) send_item(OP_ALLOC, 25'($urandom_range(32, 1)), 13'd16, '0);
    for (int i = 0; i < 10; i++) send_item(OP_FREE, '0, '0, pick_free_address());
    wait_drained();
  endtask

  task automatic test_random_traffic(int count);
    int chunk;
    chunk = count / 4;
    send_item(OP_INIT, '0, '0, '0);
    for (int mode = 0; mode < 4; mode++) begin
      sender_idle_pct = (mode == 1) ? 45 : (mode == 3) ? 30 : 0;
      receiver_stall_pct = (mode == 2) ? 45 : (mode == 3) ? 30 : 0;
      for (int i = 0; i < chunk; i++) send_random_item();
    end
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result addr=%h status=%0d",
                                    rsp.address, rsp.status));
        end else begin
          alloc_result_t e;
          e = expected_q.pop_front();
          checked_count++;
          if (rsp.address !== e.address)
            report_mismatch($sformatf("address got %h want %h", rsp.address, e.address));
          if (rsp.status !== e.status)
            report_mismatch($sformatf("status got %0d want %0d", rsp.status, e.status));
        end
      end
      rsp.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  initial begin
    #40ms;
    $display("Timeout with %0d results outstanding", expected_q.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    errors = 0;
    sent_count = 0;
    checked_count = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    req.valid = 1'b0;
    req.opcode = OP_INIT;
    req.request_bytes = '0;
    req.alignment = '0;
    req.free_address = '0;
    cfg_write = 1'b0;
    cfg_index = CFG_HEAP_START;
    cfg_data = '0;
    cfg_heap_start = 32'd1048576;
    cfg_heap_bytes = 25'd1048576;
    blk_n = 0;
    heap_top = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_table_fill();
    write_config(32'h0000_0000, 25'd4096);
    test_random_traffic(60);
    write_config(32'hFFFF_F001, 25'd16777216);
    test_random_traffic(40);
    write_config(32'h1234_5679, 25'd16777216);
    test_random_traffic(120);
    write_config(32'hFFFF_FFFF, 25'd4096);
    test_random_traffic(40);
    write_config(32'h00A0_0008, 25'd200000);
    test_random_traffic(120);
    write_config(32'd1048576, 25'd1048576);
    test_random_traffic(60);

    $display("Sent %0d transactions and checked %0d results over six heap settings,",
             sent_count, checked_count);
    $display("with idle and stall mixes on both channels; %0d mismatches.", errors);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
